// ----- rtl/adl32_pkg.sv -----
`default_nettype none
package adl32_pkg;

   localparam int BYTE_W = 8;
   localparam int COUNT_W = 4;
   localparam int SEED_W = 32;
   localparam int HALF_W = 16;
   localparam int LANE_PROD_W = 11;
   localparam int BYTE_SUM_W = 11;
   localparam int WEIGHT_SUM_W = 14;
   localparam int HIGH_ACC_W = 20;

   localparam logic [HALF_W:0] ADLER_MOD = 17'd65521;
   localparam logic [3:0] FOLD_FACTOR = 4'd15;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_val;
      logic [LANE_PROD_W-1:0] weighted;
   } lane_result_type;

   typedef struct packed {
      logic [BYTE_SUM_W-1:0] byte_sum;
      logic [WEIGHT_SUM_W-1:0] weighted;
      logic [COUNT_W-1:0] count;
   } sums_type;

endpackage
`default_nettype wire

// ----- rtl/adler32_multibyte_checksum_unit.sv -----
`default_nettype none
// Adler-32 checksum over a byte stream, up to BYTES_PER_ITEM bytes per transaction.
// One transaction is accepted every cycle while ready is high; the checksum of a final
// transaction (tlast) is offered once it has passed the merging register and the
// response register. The rate is set by the running sum update, which folds one
// whole word into both sums modulo 65521 after the byte lanes and their merging
// register. Ready falls only while a final transaction waits behind a checksum not yet taken.
// tuser carries the start flag: the sums load from seed before that word.
module adler32_multibyte_checksum_unit
   import adl32_pkg::*;
#(
   parameter int BYTES_PER_ITEM = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   // data_word, byte_count, seed, zero fill
   input  wire logic [8*BYTES_PER_ITEM+39:0] req_tdata,
   // start_req
   input  wire logic req_tuser,
   input  wire logic req_tlast,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // checksum
   output logic [SEED_W-1:0] rsp_tdata
);

   localparam int DATA_W = BYTE_W * BYTES_PER_ITEM;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(BYTES_PER_ITEM);

   logic [COUNT_W-1:0] byte_count;
   logic [COUNT_W-1:0] count_sat;
   logic accept;
   logic advance;

   lane_result_type lanes [BYTES_PER_ITEM];
   sums_type sums;

   logic stage_valid_ff;
   logic stage_valid_in;
   logic stage_start_ff;
   logic stage_last_ff;
   logic [SEED_W-1:0] stage_seed_ff;

   logic rsp_tvalid_ff;
   logic rsp_tvalid_in;
   logic [SEED_W-1:0] rsp_tdata_ff;
   logic [SEED_W-1:0] checksum_in;

   assign byte_count = req_tdata[DATA_W+COUNT_W-1:DATA_W];
   assign count_sat = (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;

   for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
      adl32_lane #(
         .LANE_INDEX(g)
      ) u_lane (
         .data_byte(req_tdata[g*BYTE_W +: BYTE_W]),
         .count(count_sat),
         .result(lanes[g])
      );
   end

   adl32_merge #(
      .BYTES_PER_ITEM(BYTES_PER_ITEM)
   ) u_merge (
      .clock(clock),
      .load(accept),
      .lanes(lanes),
      .count(count_sat),
      .sums(sums)
   );

   adl32_accum u_accum (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .sums(sums),
      .start(stage_start_ff),
      .seed(stage_seed_ff),
      .checksum_in(checksum_in)
   );

   always_comb begin
      advance = stage_valid_ff && (!stage_last_ff || !rsp_tvalid_ff || rsp_tready);
      req_tready = !stage_valid_ff || advance;
      accept = req_tvalid && req_tready;
      stage_valid_in = accept || (stage_valid_ff && !advance);
      rsp_tvalid_in = (advance && stage_last_ff) || (rsp_tvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_start_ff <= req_tuser;
         stage_last_ff <= req_tlast;
         stage_seed_ff <= req_tdata[DATA_W+COUNT_W+SEED_W-1:DATA_W+COUNT_W];
      end
      if (advance && stage_last_ff) begin
         rsp_tdata_ff <= checksum_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule
`default_nettype wire

// ----- rtl/adl32_lane.sv -----
`default_nettype none
module adl32_lane
   import adl32_pkg::*;
#(
   parameter int LANE_INDEX = 0
) (
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic [COUNT_W-1:0] count,
   output lane_result_type result
);

   localparam logic [COUNT_W-1:0] INDEX = COUNT_W'(LANE_INDEX);

   logic active;
   logic [COUNT_W-1:0] weight;
   logic [BYTE_W+COUNT_W-1:0] product;

   always_comb begin
      active = INDEX < count;
      weight = count - INDEX;
      product = data_byte * weight;
      result.byte_val = active ? data_byte : '0;
      result.weighted = active ? product[LANE_PROD_W-1:0] : '0;
   end

endmodule
`default_nettype wire

// ----- rtl/adl32_merge.sv -----
`default_nettype none
module adl32_merge
   import adl32_pkg::*;
#(
   parameter int BYTES_PER_ITEM = 8
) (
   input  wire logic clock,
   input  wire logic load,
   input  wire lane_result_type lanes [BYTES_PER_ITEM],
   input  wire logic [COUNT_W-1:0] count,
   output sums_type sums
);

   sums_type sums_ff;
   sums_type sums_in;

   always_comb begin
      sums_in.byte_sum = '0;
      sums_in.weighted = '0;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         sums_in.byte_sum = sums_in.byte_sum + BYTE_SUM_W'(lanes[i].byte_val);
         sums_in.weighted = sums_in.weighted + WEIGHT_SUM_W'(lanes[i].weighted);
      end
      sums_in.count = count;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sums_ff <= sums_in;
      end
   end

   assign sums = sums_ff;

endmodule
`default_nettype wire

// ----- rtl/adl32_accum.sv -----
`default_nettype none
module adl32_accum
   import adl32_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic advance,
   input  wire sums_type sums,
   input  wire logic start,
   input  wire logic [SEED_W-1:0] seed,
   output logic [SEED_W-1:0] checksum_in
);

   logic [HALF_W-1:0] low_ff;
   logic [HALF_W-1:0] low_in;
   logic [HALF_W-1:0] high_ff;
   logic [HALF_W-1:0] high_in;

   logic [HALF_W-1:0] low_base;
   logic [HALF_W-1:0] high_base;
   logic [HALF_W:0] low_sum;
   logic [HIGH_ACC_W-1:0] product;
   logic [HIGH_ACC_W-1:0] high_sum;
   logic [HALF_W:0] high_fold;

   always_comb begin
      low_base = start ? seed[HALF_W-1:0] : low_ff;
      high_base = start ? seed[SEED_W-1:HALF_W] : high_ff;
      low_sum = {1'b0, low_base} + (HALF_W+1)'(sums.byte_sum);
      low_in = (low_sum >= ADLER_MOD) ? HALF_W'(low_sum - ADLER_MOD) : low_sum[HALF_W-1:0];
      product = HIGH_ACC_W'(sums.count) * HIGH_ACC_W'(low_base);
      high_sum = HIGH_ACC_W'(high_base) + product + HIGH_ACC_W'(sums.weighted);
      high_fold = (HALF_W+1)'(high_sum[HALF_W-1:0])
                + ((HALF_W+1)'(high_sum[HIGH_ACC_W-1:HALF_W])
                   * (HALF_W+1)'(FOLD_FACTOR));
      high_in = (high_fold >= ADLER_MOD) ? HALF_W'(high_fold - ADLER_MOD)
                                         : high_fold[HALF_W-1:0];
      checksum_in = {high_in, low_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= HALF_W'(1);
         high_ff <= '0;
      end else if (advance) begin
         low_ff <= low_in;
         high_ff <= high_in;
      end
   end

endmodule
`default_nettype wire

// ----- sim/adler32_multibyte_checksum_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module adler32_multibyte_checksum_unit_tb
   import adl32_pkg::*;
();

   localparam int LANES = 8;
   localparam int TDATA_W = 8*LANES+40;
   localparam int ADLER_PRIME = 65521;
   localparam int HOLD_CYCLES = 200;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SEED_W-1:0] rsp_tdata;

   logic [HALF_W-1:0] run_low = 16'd1;
   logic [HALF_W-1:0] run_high = 16'd0;
   logic [SEED_W-1:0] checksum_q[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_count = 0;
   logic holding = 1'b0;
   event hold_trigger;

   adler32_multibyte_checksum_unit #(.BYTES_PER_ITEM(LANES)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("** adler32_multibyte_checksum_unit: FAILED **");
      $finish;
   end

   // advance the running sums by one accepted transaction
   task automatic predict_checksum(input logic [63:0] word, input logic [3:0] cnt,
                                   input logic is_start, input logic [31:0] seed,
                                   input logic is_last);
      longint unsigned n;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned byte_sum;
      longint unsigned weighted;
      longint unsigned b;
      byte_sum = 0;
      weighted = 0;
      if (is_start) begin
         run_low = seed[15:0];
         run_high = seed[31:16];
      end
      n = (cnt > 4'(LANES)) ? 64'(LANES) : 64'(cnt);
      for (int i = 0; i < n; i++) begin
         b = 64'(word[8*i +: 8]);
         byte_sum += b;
         weighted += (n - 64'(i)) * b;
      end
      lo = 64'(run_low);
      hi = 64'(run_high) + n * lo + weighted;
      lo = lo + byte_sum;
      run_low = HALF_W'(lo % 64'(ADLER_PRIME));
      run_high = HALF_W'(hi % 64'(ADLER_PRIME));
      if (is_last)
         checksum_q.push_back({run_high, run_low});
   endtask

   task automatic send_item(input logic [63:0] word, input logic [3:0] cnt,
                            input logic is_start, input logic [31:0] seed,
                            input logic is_last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, seed, cnt, word};
      req_tuser <= is_start;
      req_tlast <= is_last;
      do @(posedge clock); while (!req_tready);
      predict_checksum(word, cnt, is_start, seed, is_last);
   endtask

   task automatic set_idling(input int req_pct, input int rsp_pct);
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [3:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 75) return 4'($urandom_range(1, 8));
      if (r < 88) return 4'd8;
      if (r < 94) return 4'd0;
      return 4'($urandom_range(9, 15));
   endfunction

   function automatic logic [31:0] pick_seed();
      int r;
      r = $urandom_range(99);
      if (r < 40) return 32'd1;
      if (r < 80) return {16'($urandom_range(0, ADLER_PRIME-1)),
                          16'($urandom_range(0, ADLER_PRIME-1))};
      return $urandom;
   endfunction

   always @(posedge clock)
      rsp_tready <= !holding && ($urandom_range(99) >= rsp_idle_pct);

   initial begin
      forever begin
         @(hold_trigger);
         holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (checksum_q.size() == 0) begin
            if (mismatch_count < MAX_REPORTS)
               $display("unexpected checksum transaction: actual %h", rsp_tdata);
            mismatch_count++;
         end else if (rsp_tdata !== checksum_q[0]) begin
            if (mismatch_count < MAX_REPORTS)
               $display("checksum mismatch: expected %h actual %h",
                        checksum_q[0], rsp_tdata);
            mismatch_count++;
            void'(checksum_q.pop_front());
         end else begin
            void'(checksum_q.pop_front());
         end
      end
   end

   task automatic test_directed_cases();
      // reset sums without a start
      send_item(64'h61, 4'd1, 1'b0, 32'd0, 1'b1);
      send_item({8{8'hff}}, 4'd8, 1'b1, 32'd1, 1'b1);
      send_item(64'd0, 4'd8, 1'b1, 32'd0, 1'b1);
      // zero count, seed halves above the modulus
      send_item({8{8'hff}}, 4'd0, 1'b1, 32'hffff_ffff, 1'b1);
      send_item({8{8'hff}}, 4'd15, 1'b1, 32'd1, 1'b0);
      send_item(64'h0123_4567_89ab_cdef, 4'd9, 1'b0, 32'd0, 1'b0);
      // ignore bytes above the count
      send_item(64'hdead_beef_cafe_0102, 4'd3, 1'b0, 32'hffff_ffff, 1'b1);
      send_item(64'h7f, 4'd1, 1'b1, {16'd65521, 16'd65521}, 1'b1);
      send_item({8{8'hff}}, 4'd8, 1'b1, {16'd65520, 16'd65520}, 1'b1);
      send_item({8{8'ha5}}, 4'd8, 1'b1, 32'd1, 1'b0);
      send_item({8{8'h5a}}, 4'd4, 1'b0, 32'd0, 1'b0);
      send_item(64'd0, 4'd0, 1'b0, 32'd0, 1'b0);
      send_item(64'h8000_0000_0000_0001, 4'd7, 1'b0, 32'd0, 1'b1);
      // restart in the middle of a message
      send_item(64'h1122_3344_5566_7788, 4'd8, 1'b0, 32'd0, 1'b0);
      send_item(64'h8000_0000_0000_0000, 4'd8, 1'b1, 32'h8000_0000, 1'b0);
      send_item(64'hffff_ffff_0000_0000, 4'd8, 1'b0, 32'h7fff_ffff, 1'b1);
      send_item(64'h5555_5555_5555_5555, 4'd2, 1'b1, 32'h0000_ffff, 1'b1);
   endtask

   task automatic test_random_traffic(input int n_items, input int req_pct,
                                      input int rsp_pct);
      int sent;
      int len;
      logic [31:0] seed;
      set_idling(req_pct, rsp_pct);
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            send_item(rand_word(), 4'($urandom), 1'($urandom), $urandom, 1'($urandom));
            sent++;
         end else begin
            len = $urandom_range(1, 10);
            seed = pick_seed();
            for (int k = 0; k < len; k++) begin
               send_item(rand_word(), pick_count(), k == 0, (k == 0) ? seed : $urandom,
                         k == len - 1);
               sent++;
            end
         end
      end
   endtask

   task automatic test_output_stall();
      set_idling(0, 0);
      -> hold_trigger;
      for (int k = 0; k < 40; k++)
         send_item(rand_word(), pick_count(), 1'($urandom), pick_seed(), 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(15, 58);
      test_directed_cases();
      test_random_traffic(240, 15, 58);
      test_random_traffic(240, 58, 15);
      test_random_traffic(240, 0, 0);
      test_output_stall();
      req_tvalid <= 1'b0;
      set_idling(0, 0);
      while (checksum_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && checksum_q.size() == 0) begin
         $display("** adler32_multibyte_checksum_unit: PASSED **");
      end else begin
         $display("** adler32_multibyte_checksum_unit: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
